@@ rtl/core/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Holds the request/result payload structs and the controller command struct.
// No dependencies.
`default_nettype none

package dq_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int ELEM_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Request codes
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Request transaction
  typedef struct packed {
    op_t                       operation;
    logic signed [ELEM_W-1:0]  push_value;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic signed [ELEM_W-1:0]  popped_value;
    logic [1:0]                status;
    logic                      is_empty;
    logic [CNT_W-1:0]          item_count;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // execute the request on the input bus this cycle
    logic load;    // move the finished result into the output register
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/dq_ctrl.sv @@
// Handshake controller for the double-ended queue.
// Sequences accept, execute and result load; depends on dq_pkg.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire  out_stall,
  output cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t state_r, state_nxt;
  logic   stall_r, stall_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   accept, load, out_free;

  // Output register is free when empty or being taken this cycle
  assign out_free = !ovalid_r || !out_stall;
  assign accept   = (state_r == S_IDLE) && in_valid;
  assign load     = (state_r == S_BUSY) && out_free;

  // Next state and registered outputs
  always_comb begin
    state_nxt  = state_r;
    stall_nxt  = stall_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_BUSY;
          stall_nxt = 1'b1;
        end
      end
      S_BUSY: begin
        if (out_free) begin
          state_nxt  = S_IDLE;
          stall_nxt  = 1'b0;
          ovalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        stall_nxt = 1'b0;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      stall_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stall_r  <= stall_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall   = stall_r;
  assign out_valid  = ovalid_r;
  assign cmd.accept = accept;
  assign cmd.load   = load;

endmodule

`default_nettype wire

@@ rtl/core/dq_dpath.sv @@
// Datapath of the double-ended queue: ring store, front pointer, count and
// result register. Driven by dq_ctrl commands; depends on dq_pkg.
`default_nettype none

module dq_dpath
  import dq_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  cmd_t cmd,
  input  in_t  in_data,
  output out_t out_data
);

  logic [ELEM_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ELEM_W-1:0] rd_data_r;
  logic              pop_ok_r;
  status_t           status_r, status_nxt;
  out_t              out_r;

  logic              full, empty, wr_en, rd_en;
  logic [IDX_W-1:0]  addr, front_dec, front_inc, back_slot, tail_slot;
  logic [CNT_W:0]    sum_tail, sum_back;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  // Ring index arithmetic with explicit wrap
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign sum_tail  = {{(CNT_W + 1 - IDX_W){1'b0}}, front_r} + {1'b0, cnt_r};
  assign sum_back  = sum_tail - 1'b1;
  assign tail_slot = (sum_tail >= (CNT_W + 1)'(DEPTH)) ?
                     IDX_W'(sum_tail - (CNT_W + 1)'(DEPTH)) : IDX_W'(sum_tail);
  assign back_slot = (sum_back >= (CNT_W + 1)'(DEPTH)) ?
                     IDX_W'(sum_back - (CNT_W + 1)'(DEPTH)) : IDX_W'(sum_back);

  // Decode the request against the current fill
  always_comb begin
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    addr       = front_r;
    front_nxt  = front_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    case (in_data.operation)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          addr      = front_dec;
          front_nxt = front_dec;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          addr    = tail_slot;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          front_nxt = front_inc;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          addr    = back_slot;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Ring store: at most one write or one registered read per request
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[addr] <= in_data.push_value;
    end
    if (cmd.accept && rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Advance pointer and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.accept) begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold per-request status until the result is loaded
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= status_nxt;
      pop_ok_r <= rd_en;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.popped_value <= pop_ok_r ? rd_data_r : '0;
      out_r.status       <= status_r;
      out_r.is_empty     <= (cnt_r == '0);
      out_r.item_count   <= cnt_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ rtl/core/double_ended_queue.sv @@
// Double-ended queue of signed elements in a 16-entry ring store.
// A request is accepted in S_IDLE; its result is loaded into the output register from
// S_BUSY once that register is free, and out_valid rises with it. No new request is
// accepted until the last result is loaded; stalls on the output hold the controller in S_BUSY.
// Reset (rst_n low, synchronous) empties the queue; store contents stay undefined.
// Depends on dq_pkg, dq_ctrl and dq_dpath.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  wire  out_stall,
  output out_t out_data
);

  cmd_t cmd;

  // Handshake sequencing
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Store, pointers and result register
  dq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
